[sv/ilid_pkg.sv]
package ilid_pkg;

  localparam int REQ_W = 3;
  localparam int POS_W = 7;
  localparam int PT_W  = 32;
  localparam int CNT_W = 8;

  localparam logic [REQ_W-1:0] REQ_SET    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_GET    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GET,
    ST_SHIFT
  } state_t;

endpackage

[sv/ilid_ram.sv]
module ilid_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/indexed_list_insert_delete.sv]
// Channel  | Ports                                          | Handshake
// request  | in_req_type, in_position, in_point_in          | start && !busy
// result   | out_point_out, out_entry_count, out_rejected   | out_valid, one cycle
//
// Set, append and rejected requests: result one cycle after the beat; busy stays low.
// Get: one memory read, busy in ST_GET; result via the RAM read and output registers.
// Remove and insert move one entry per cycle while busy, from the end of the list on
// insert and from the position on remove; the result comes when busy drops.
// Reset clears state, count, pending read and out_valid; the memory needs no clearing pass.
// The receiver cannot stall: every result is shown for exactly one cycle.
module indexed_list_insert_delete #(
  parameter int CAPACITY   = 128,
  parameter int POINT_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ilid_pkg::REQ_W-1:0]  in_req_type,
  input  logic [ilid_pkg::POS_W-1:0]  in_position,
  input  logic [ilid_pkg::PT_W-1:0]   in_point_in,
  output logic                        out_valid,
  output logic [ilid_pkg::PT_W-1:0]   out_point_out,
  output logic [ilid_pkg::CNT_W-1:0]  out_entry_count,
  output logic                        out_rejected
);

  import ilid_pkg::*;

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int EXW  = (CW > CNT_W) ? CW : CNT_W;
  localparam int PXW  = (POINT_BITS > PT_W) ? POINT_BITS : PT_W;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [IW-1:0]         pos_r, pos_nxt;
  logic [POINT_BITS-1:0] pt_r, pt_nxt;
  logic                  ins_r, ins_nxt;
  logic [IW-1:0]         rd_addr_r, rd_addr_nxt;
  logic [IW-1:0]         wr_addr_r, wr_addr_nxt;
  logic [CW-1:0]         rd_left_r, rd_left_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [PT_W-1:0]       out_point_r, out_point_nxt;
  logic [CNT_W-1:0]      out_count_r, out_count_nxt;
  logic                  out_rej_r, out_rej_nxt;

  logic                  ram_we, ram_re;
  logic [IW-1:0]         ram_waddr, ram_raddr;
  logic [POINT_BITS-1:0] ram_wdata, ram_rdata;

  logic [CMPW-1:0]       pos_ext, cnt_cmp;
  logic [PXW-1:0]        pt_ext, rd_ext;
  logic [POINT_BITS-1:0] pt_st;
  logic [IW-1:0]         pos_idx, cnt_idx;
  logic                  pos_ok, not_full, accept;

  assign pos_ext  = CMPW'(in_position);
  assign cnt_cmp  = CMPW'(cnt_r);
  assign pos_idx  = pos_ext[IW-1:0];
  assign cnt_idx  = cnt_r[IW-1:0];
  assign pos_ok   = pos_ext < cnt_cmp;
  assign not_full = cnt_r < CW'(CAPACITY);
  assign pt_ext   = PXW'(in_point_in);
  assign pt_st    = pt_ext[POINT_BITS-1:0];
  assign rd_ext   = PXW'(ram_rdata);
  assign accept   = start && (state_r == ST_IDLE);

  function automatic logic [CNT_W-1:0] count_out(input logic [CW-1:0] c);
    logic [EXW-1:0] e;
    e = EXW'(c);
    return e[CNT_W-1:0];
  endfunction

  ilid_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (POINT_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r       <= pos_nxt;
    pt_r        <= pt_nxt;
    ins_r       <= ins_nxt;
    rd_addr_r   <= rd_addr_nxt;
    wr_addr_r   <= wr_addr_nxt;
    rd_left_r   <= rd_left_nxt;
    out_point_r <= out_point_nxt;
    out_count_r <= out_count_nxt;
    out_rej_r   <= out_rej_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    pt_nxt        = pt_r;
    ins_nxt       = ins_r;
    rd_addr_nxt   = rd_addr_r;
    wr_addr_nxt   = wr_addr_r;
    rd_left_nxt   = rd_left_r;
    rd_pend_nxt   = 1'b0;
    out_valid_nxt = 1'b0;
    out_point_nxt = '0;
    out_count_nxt = count_out(cnt_r);
    out_rej_nxt   = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = pos_idx;
    ram_wdata     = pt_st;
    ram_re        = 1'b0;
    ram_raddr     = pos_idx;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pos_nxt = pos_idx;
          pt_nxt  = pt_st;
          case (in_req_type)
            REQ_SET: begin
              ram_we        = pos_ok;
              out_valid_nxt = 1'b1;
              out_rej_nxt   = !pos_ok;
            end
            REQ_GET: begin
              if (pos_ok) begin
                ram_re    = 1'b1;
                state_nxt = ST_GET;
              end else begin
                out_valid_nxt = 1'b1;
                out_rej_nxt   = 1'b1;
              end
            end
            REQ_APPEND: begin
              out_valid_nxt = 1'b1;
              if (not_full) begin
                ram_we        = 1'b1;
                ram_waddr     = cnt_idx;
                cnt_nxt       = cnt_r + 1'b1;
                out_count_nxt = count_out(cnt_r + 1'b1);
              end else begin
                out_rej_nxt = 1'b1;
              end
            end
            REQ_REMOVE: begin
              if (pos_ok) begin
                ins_nxt     = 1'b0;
                rd_addr_nxt = pos_idx + 1'b1;
                wr_addr_nxt = pos_idx;
                rd_left_nxt = cnt_r - 1'b1 - pos_ext[CW-1:0];
                state_nxt   = ST_SHIFT;
              end else begin
                out_valid_nxt = 1'b1;
                out_rej_nxt   = 1'b1;
              end
            end
            REQ_INSERT: begin
              if (pos_ok && not_full) begin
                ins_nxt     = 1'b1;
                rd_addr_nxt = cnt_idx - 1'b1;
                wr_addr_nxt = cnt_idx;
                rd_left_nxt = cnt_r - pos_ext[CW-1:0];
                state_nxt   = ST_SHIFT;
              end else begin
                out_valid_nxt = 1'b1;
                out_rej_nxt   = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_rej_nxt   = 1'b1;
            end
          endcase
        end
      end
      ST_GET: begin
        out_valid_nxt = 1'b1;
        out_point_nxt = rd_ext[PT_W-1:0];
        state_nxt     = ST_IDLE;
      end
      ST_SHIFT: begin
        // read one entry ahead, write the previous read behind it
        ram_raddr = rd_addr_r;
        if (rd_left_r != '0) begin
          ram_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_left_nxt = rd_left_r - 1'b1;
          rd_addr_nxt = ins_r ? rd_addr_r - 1'b1 : rd_addr_r + 1'b1;
        end
        if (rd_pend_r) begin
          ram_we      = 1'b1;
          ram_waddr   = wr_addr_r;
          ram_wdata   = ram_rdata;
          wr_addr_nxt = ins_r ? wr_addr_r - 1'b1 : wr_addr_r + 1'b1;
        end
        if ((rd_left_r == '0) && !rd_pend_r) begin
          if (ins_r) begin
            ram_we        = 1'b1;
            ram_waddr     = pos_r;
            ram_wdata     = pt_r;
            cnt_nxt       = cnt_r + 1'b1;
            out_count_nxt = count_out(cnt_r + 1'b1);
          end else begin
            cnt_nxt       = cnt_r - 1'b1;
            out_count_nxt = count_out(cnt_r - 1'b1);
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_point_out   = out_point_r;
  assign out_entry_count = out_count_r;
  assign out_rejected    = out_rej_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("read and write of the same entry in one cycle");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rej_r |-> cnt_r == $past(cnt_r))
    else $error("rejected request changed the count");

  a_beat_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted beat neither busy nor answered");

endmodule

[test/indexed_list_insert_delete_test.sv]
module indexed_list_insert_delete_test;

  import ilid_pkg::*;

  localparam int LIST_DEPTH = 128;
  localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_MID   = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [PT_W-1:0]  point;
    logic [CNT_W-1:0] count;
    logic             rejected;
  } list_result_t;

  class point_list_scoreboard;
    logic [PT_W-1:0] shadow_cells [LIST_DEPTH];
    int unsigned     shadow_count;
    list_result_t    awaited_results [$];
    int unsigned     mismatches;
    int unsigned     results_checked;
    int unsigned     rejects;
    int unsigned     peak_count;
    int unsigned     kind_seen [8];

    function new();
      shadow_count = 0;
      mismatches = 0;
      results_checked = 0;
      rejects = 0;
      peak_count = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    task report_mismatch(input string what, input logic [PT_W-1:0] got,
                         input logic [PT_W-1:0] want);
      if (mismatches < 50) begin
        $display("mismatch: %s got %h want %h", what, got, want);
      end
      mismatches++;
    endtask

    function void note_request(input logic [REQ_W-1:0] kind,
                               input logic [POS_W-1:0] pos,
                               input logic [PT_W-1:0] point);
      list_result_t want;
      want = '0;
      kind_seen[kind]++;
      case (kind)
        REQ_SET: begin
          if (pos < shadow_count) shadow_cells[pos] = point;
          else want.rejected = 1'b1;
        end
        REQ_GET: begin
          if (pos < shadow_count) want.point = shadow_cells[pos];
          else want.rejected = 1'b1;
        end
        REQ_APPEND: begin
          if (shadow_count < LIST_DEPTH) begin
            shadow_cells[shadow_count] = point;
            shadow_count++;
          end else begin
            want.rejected = 1'b1;
          end
        end
        REQ_REMOVE: begin
          if (pos < shadow_count) begin
            for (int i = pos; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i + 1];
            shadow_count--;
          end else begin
            want.rejected = 1'b1;
          end
        end
        REQ_INSERT: begin
          if (pos < shadow_count && shadow_count < LIST_DEPTH) begin
            for (int i = shadow_count; i > pos; i--) shadow_cells[i] = shadow_cells[i - 1];
            shadow_cells[pos] = point;
            shadow_count++;
          end else begin
            want.rejected = 1'b1;
          end
        end
        default: want.rejected = 1'b1;
      endcase
      if (want.rejected) rejects++;
      if (shadow_count > peak_count) peak_count = shadow_count;
      want.count = shadow_count[CNT_W-1:0];
      awaited_results.push_back(want);
    endfunction

    task check_result(input logic [PT_W-1:0] point, input logic [CNT_W-1:0] count,
                      input logic rejected);
      list_result_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch("result beat with nothing awaited", point, '0);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (point !== want.point) report_mismatch("out_point_out", point, want.point);
        if (count !== want.count) begin
          report_mismatch("out_entry_count", PT_W'(count), PT_W'(want.count));
        end
        if (rejected !== want.rejected) begin
          report_mismatch("out_rejected", PT_W'(rejected), PT_W'(want.rejected));
        end
      end
    endtask
  endclass

  typedef enum int {
    MIX_GROW,
    MIX_FILL,
    MIX_DRAIN
  } mix_t;

  localparam int CYCLE_LIMIT = 500000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [REQ_W-1:0] in_req_type = REQ_SET;
  logic [POS_W-1:0] in_position = '0;
  logic [PT_W-1:0]  in_point_in = '0;
  logic             out_valid;
  logic [PT_W-1:0]  out_point_out;
  logic [CNT_W-1:0] out_entry_count;
  logic             out_rejected;

  point_list_scoreboard sb;
  int unsigned          cycles = 0;

  indexed_list_insert_delete dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_point_in    (in_point_in),
    .out_valid      (out_valid),
    .out_point_out  (out_point_out),
    .out_entry_count(out_entry_count),
    .out_rejected   (out_rejected)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      sb.check_result(out_point_out, out_entry_count, out_rejected);
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [PT_W-1:0] point);
    in_req_type <= kind;
    in_position <= pos;
    in_point_in <= point;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(kind, pos, point);
  endtask

  task automatic maybe_idle(input bit calm);
    if (!calm) begin
      while ($urandom_range(99, 0) < 27) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic await_all_results();
    start <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [REQ_W-1:0] pick_unused_kind();
    return REQ_W'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
  endfunction

  function automatic logic [REQ_W-1:0] pick_kind(input mix_t mix);
    int weights [6];
    int roll;
    int acc;
    int idx;
    case (mix)
      MIX_GROW:  weights = '{15, 20, 30, 10, 20, 5};
      MIX_FILL:  weights = '{10, 10, 60, 5, 12, 3};
      default:   weights = '{10, 15, 8, 52, 10, 5};
    endcase
    roll = $urandom_range(99, 0);
    acc = 0;
    idx = 5;
    for (int k = 0; k < 6; k++) begin
      acc += weights[k];
      if (roll < acc) begin
        idx = k;
        break;
      end
    end
    case (idx)
      0: return REQ_SET;
      1: return REQ_GET;
      2: return REQ_APPEND;
      3: return REQ_REMOVE;
      4: return REQ_INSERT;
      default: return pick_unused_kind();
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int roll;
    int unsigned used;
    used = sb.shadow_count;
    roll = $urandom_range(99, 0);
    if (used == 0 || roll < 12) return POS_W'($urandom_range(127, 0));
    if (roll < 20) return POS_W'(used);
    if (roll < 28) return POS_W'(used - 1);
    if (roll < 34) return '0;
    return POS_W'($urandom_range(used - 1, 0));
  endfunction

  function automatic logic [PT_W-1:0] pick_point();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    return $urandom;
  endfunction

  task automatic random_requests(input int count, input mix_t mix, input bit calm);
    for (int n = 0; n < count; n++) begin
      send_request(pick_kind(mix), pick_position(), pick_point());
      maybe_idle(calm);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_request(REQ_GET, 7'd0, 32'h0);
    send_request(REQ_SET, 7'd0, 32'hDEAD_BEEF);
    send_request(REQ_REMOVE, 7'd0, 32'h0);
    send_request(REQ_INSERT, 7'd0, 32'h1111_1111);
    send_request(REQ_APPEND, 7'd0, 32'h0000_0000);
    send_request(REQ_APPEND, 7'd127, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 7'd0, 32'hA5A5_5A5A);
    send_request(REQ_INSERT, 7'd2, 32'h1234_5678);
    send_request(REQ_INSERT, 7'd4, 32'h5555_AAAA);
    send_request(REQ_GET, 7'd0, 32'h0);
    send_request(REQ_GET, 7'd1, 32'h0);
    send_request(REQ_GET, 7'd2, 32'h0);
    send_request(REQ_GET, 7'd3, 32'h0);
    send_request(REQ_SET, 7'd3, 32'h8000_0001);
    send_request(REQ_GET, 7'd3, 32'hFFFF_FFFF);
    send_request(REQ_GET, 7'd127, 32'h0);
    send_request(REQ_SET, 7'd127, 32'h7FFF_FFFE);
    send_request(REQ_UNUSED_FIRST, 7'd0, 32'h0);
    send_request(REQ_UNUSED_MID, 7'd1, 32'hFFFF_FFFF);
    send_request(REQ_UNUSED_LAST, 7'd127, 32'h0);
    send_request(REQ_REMOVE, 7'd3, 32'h0);
    send_request(REQ_REMOVE, 7'd0, 32'h0);
    send_request(REQ_GET, 7'd0, 32'h0);
    await_all_results();

    random_requests(60, MIX_GROW, 1'b1);
    random_requests(90, MIX_GROW, 1'b0);
    await_all_results();

    for (int guard = 0; guard < 600 && sb.shadow_count < LIST_DEPTH; guard++) begin
      random_requests(1, MIX_FILL, 1'b0);
    end
    random_requests(40, MIX_FILL, 1'b0);
    random_requests(150, MIX_DRAIN, 1'b0);

    start <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.awaited_results.size() != 0) begin
      sb.report_mismatch("results never delivered", PT_W'(sb.awaited_results.size()), '0);
    end
    $display("covered set %0d get %0d append %0d remove %0d insert %0d other %0d, %0d rejected",
             sb.kind_seen[REQ_SET], sb.kind_seen[REQ_GET], sb.kind_seen[REQ_APPEND],
             sb.kind_seen[REQ_REMOVE], sb.kind_seen[REQ_INSERT],
             sb.kind_seen[REQ_UNUSED_FIRST] + sb.kind_seen[REQ_UNUSED_MID] +
             sb.kind_seen[REQ_UNUSED_LAST], sb.rejects);
    $display("list peaked at %0d of %0d entries; %0d result beats checked, %0d mismatches",
             sb.peak_count, LIST_DEPTH, sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
